// ===== rtl/pcfwl_pkg.sv =====
// shared types and constants for the per-client fixed-window limiter
// used by pcfwl_table, pcfwl_cmp and per_client_fixed_window_limiter
package pcfwl_pkg;

  localparam int TIME_W  = 32;
  localparam int CFG_W   = 31;
  localparam int COUNT_W = 16;
  localparam int KEY_W   = 64;
  localparam int CIDX_W  = 2;

  // register indexes of the configuration port
  localparam logic [CIDX_W-1:0] CFG_REQUEST_LIMIT  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_WINDOW_LENGTH  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_IDLE_TIMEOUT   = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_SWEEP_INTERVAL = 2'd3;

  // verdict codes
  localparam logic [1:0] VERDICT_ALLOWED = 2'd0;
  localparam logic [1:0] VERDICT_LIMITED = 2'd1;
  localparam logic [1:0] VERDICT_FULL    = 2'd2;

  // reset values of the configuration registers
  localparam logic [COUNT_W-1:0] RST_REQUEST_LIMIT  = 16'd60;
  localparam logic [CFG_W-1:0]   RST_WINDOW_LENGTH  = 31'd60000;
  localparam logic [CFG_W-1:0]   RST_IDLE_TIMEOUT   = 31'd600000;
  localparam logic [CFG_W-1:0]   RST_SWEEP_INTERVAL = 31'd600000;

  // one client table row
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key_hi;
    logic [KEY_W-1:0]   key_lo;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  wstart;
    logic [TIME_W-1:0]  last;
  } entry_t;

endpackage

// ===== rtl/per_client_fixed_window_limiter.sv =====
// Per-client fixed-window request limiter, top level with its sequencer.
// Input channel: in_valid_i / in_stall_o carry one request transaction
// (client_high_i, client_low_i, now_time_i). Output channel: out_valid_o /
// out_stall_i carry one verdict per request (0 allowed, 1 limited, 2 table
// full). Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 request limit, 1 window length, 2 idle timeout, 3 sweep interval).
// One request at a time runs through the client table with a single read and
// a single write port, reading and then checking one row at a time; one
// subtract-compare unit does every modular time check. A request scans the
// rows until its key is found or every row has been seen; when an idle sweep
// is due, a pass over every row comes first.
// After reset a clearing pass marks every row free; requests are held off
// (in_stall_o high) meanwhile.
// The verdict sits in an output register; the next request is taken while it
// waits, and a stalled receiver only holds the block at its final step.
// Depends on pcfwl_pkg, pcfwl_table and pcfwl_cmp.
module per_client_fixed_window_limiter
  import pcfwl_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [KEY_W-1:0]  client_high_i,
  input  logic [KEY_W-1:0]  client_low_i,
  input  logic [TIME_W-1:0] now_time_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        verdict_o,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // sequencer codes
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLEAR = 4'd1;
  localparam logic [3:0] ST_SWCHK = 4'd2;
  localparam logic [3:0] ST_SWRD  = 4'd3;
  localparam logic [3:0] ST_SWEV  = 4'd4;
  localparam logic [3:0] ST_LKRD  = 4'd5;
  localparam logic [3:0] ST_LKEV  = 4'd6;
  localparam logic [3:0] ST_WIN   = 4'd7;
  localparam logic [3:0] ST_LIM   = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  logic [3:0]         state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               free_found_q, free_found_d;
  logic [IDX_W-1:0]   free_idx_q, free_idx_d;
  logic [TIME_W-1:0]  last_sweep_q, last_sweep_d;
  logic               out_valid_q, out_valid_d;

  logic [COUNT_W-1:0] req_limit_q;
  logic [CFG_W-1:0]   win_len_q;
  logic [CFG_W-1:0]   idle_to_q;
  logic [CFG_W-1:0]   sweep_int_q;

  logic [KEY_W-1:0]   key_hi_q, key_hi_d;
  logic [KEY_W-1:0]   key_lo_q, key_lo_d;
  logic [TIME_W-1:0]  now_q, now_d;
  entry_t             rec_q, rec_d;
  logic [IDX_W-1:0]   slot_q, slot_d;
  logic [1:0]         verdict_q, verdict_d;
  logic [1:0]         out_verdict_q, out_verdict_d;

  logic               in_acc;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;
  entry_t             mem_rdata;
  logic [TIME_W-1:0]  cmp_then;
  logic [CFG_W-1:0]   cmp_limit;
  logic               cmp_expired;
  logic               key_hit;
  logic               free_now;
  logic [IDX_W-1:0]   free_sel;
  entry_t             new_rec;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign verdict_o   = out_verdict_q;

  // client table
  pcfwl_table #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (IDX_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata)
  );

  // shared time unit operand select
  always_comb begin
    cmp_then  = last_sweep_q;
    cmp_limit = sweep_int_q;
    case (state_q)
      ST_SWEV: begin
        cmp_then  = mem_rdata.last;
        cmp_limit = idle_to_q;
      end
      ST_WIN: begin
        cmp_then  = rec_q.wstart;
        cmp_limit = win_len_q;
      end
      default: begin
        cmp_then  = last_sweep_q;
        cmp_limit = sweep_int_q;
      end
    endcase
  end

  pcfwl_cmp u_cmp (
    .now_i     (now_q),
    .then_i    (cmp_then),
    .limit_i   (cmp_limit),
    .expired_o (cmp_expired)
  );

  // lookup helpers
  assign key_hit  = mem_rdata.valid && (mem_rdata.key_hi == key_hi_q)
                    && (mem_rdata.key_lo == key_lo_q);
  assign free_now = free_found_q || !mem_rdata.valid;
  assign free_sel = free_found_q ? free_idx_q : idx_q;

  always_comb begin
    new_rec        = '0;
    new_rec.valid  = 1'b1;
    new_rec.key_hi = key_hi_q;
    new_rec.key_lo = key_lo_q;
    new_rec.count  = '0;
    new_rec.wstart = now_q;
    new_rec.last   = now_q;
  end

  // sequencer
  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    free_found_d  = free_found_q;
    free_idx_d    = free_idx_q;
    last_sweep_d  = last_sweep_q;
    out_valid_d   = out_valid_q && out_stall_i;
    key_hi_d      = key_hi_q;
    key_lo_d      = key_lo_q;
    now_d         = now_q;
    rec_d         = rec_q;
    slot_d        = slot_q;
    verdict_d     = verdict_q;
    out_verdict_d = out_verdict_q;
    mem_we        = 1'b0;
    mem_waddr     = idx_q;
    mem_wdata     = mem_rdata;

    case (state_q)
      ST_CLEAR: begin
        mem_we          = 1'b1;
        mem_wdata       = '0;
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          key_hi_d = client_high_i;
          key_lo_d = client_low_i;
          now_d    = now_time_i;
          state_d  = ST_SWCHK;
        end
      end
      ST_SWCHK: begin
        idx_d        = '0;
        free_found_d = 1'b0;
        if (cmp_expired) begin
          last_sweep_d = now_q;
          state_d      = ST_SWRD;
        end else begin
          state_d = ST_LKRD;
        end
      end
      ST_SWRD: begin
        state_d = ST_SWEV;
      end
      ST_SWEV: begin
        // free a row idle for too long
        if (mem_rdata.valid && cmp_expired) begin
          mem_we          = 1'b1;
          mem_wdata       = mem_rdata;
          mem_wdata.valid = 1'b0;
        end
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = ST_LKRD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_SWRD;
        end
      end
      ST_LKRD: begin
        state_d = ST_LKEV;
      end
      ST_LKEV: begin
        if (key_hit) begin
          rec_d   = mem_rdata;
          slot_d  = idx_q;
          idx_d   = '0;
          state_d = ST_WIN;
        end else begin
          if (!mem_rdata.valid && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = idx_q;
          end
          if (idx_q == LAST_IDX) begin
            idx_d = '0;
            if (free_now) begin
              rec_d   = new_rec;
              slot_d  = free_sel;
              state_d = ST_WIN;
            end else begin
              verdict_d = VERDICT_FULL;
              state_d   = ST_DONE;
            end
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_LKRD;
          end
        end
      end
      ST_WIN: begin
        // restart the window when it has run out
        rec_d.last = now_q;
        if (cmp_expired) begin
          rec_d.count  = '0;
          rec_d.wstart = now_q;
        end
        state_d = ST_LIM;
      end
      ST_LIM: begin
        mem_we    = 1'b1;
        mem_waddr = slot_q;
        mem_wdata = rec_q;
        if (rec_q.count >= req_limit_q) begin
          verdict_d = VERDICT_LIMITED;
        end else begin
          mem_wdata.count = rec_q.count + 1'b1;
          verdict_d       = VERDICT_ALLOWED;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d   = 1'b1;
          out_verdict_d = verdict_q;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      idx_q        <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      last_sweep_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      free_found_q <= free_found_d;
      free_idx_q   <= free_idx_d;
      last_sweep_q <= last_sweep_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_limit_q <= RST_REQUEST_LIMIT;
      win_len_q   <= RST_WINDOW_LENGTH;
      idle_to_q   <= RST_IDLE_TIMEOUT;
      sweep_int_q <= RST_SWEEP_INTERVAL;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_REQUEST_LIMIT:  req_limit_q <= cfg_data_i[COUNT_W-1:0];
        CFG_WINDOW_LENGTH:  win_len_q   <= cfg_data_i;
        CFG_IDLE_TIMEOUT:   idle_to_q   <= cfg_data_i;
        CFG_SWEEP_INTERVAL: sweep_int_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_hi_q      <= key_hi_d;
    key_lo_q      <= key_lo_d;
    now_q         <= now_d;
    rec_q         <= rec_d;
    slot_q        <= slot_d;
    verdict_q     <= verdict_d;
    out_verdict_q <= out_verdict_d;
  end

  // a new verdict only comes out of the final step
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("verdict issued outside final step");

  // no reserved verdict code ever leaves the block
  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_verdict_q == VERDICT_ALLOWED ||
                     out_verdict_q == VERDICT_LIMITED ||
                     out_verdict_q == VERDICT_FULL))
    else $error("reserved verdict code");

  // the update write always leaves a live row
  a_update_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LIM) |-> (mem_we && mem_wdata.valid))
    else $error("update write drops the row");

  // sweep time moves only when a sweep starts
  a_sweep_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(last_sweep_q) |-> ($past(state_q == ST_SWCHK) && state_q == ST_SWRD))
    else $error("sweep time changed outside sweep start");

  // every scan leaves the row index at zero
  a_idx_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_WIN || state_q == ST_DONE) |-> (idx_q == '0))
    else $error("row index not rewound");

endmodule

// ===== rtl/pcfwl_table.sv =====
// client table memory: one write port, one read port with registered data
// depends on pcfwl_pkg for the row type
module pcfwl_table
  import pcfwl_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pcfwl_cmp.sv =====
// shared modular time unit: (now - then) mod 2^32 compared against a limit
// depends on pcfwl_pkg for widths
module pcfwl_cmp
  import pcfwl_pkg::*;
(
  input  logic [TIME_W-1:0] now_i,
  input  logic [TIME_W-1:0] then_i,
  input  logic [CFG_W-1:0]  limit_i,
  output logic              expired_o
);

  logic [TIME_W-1:0] diff;

  // wrapping difference, then unsigned compare
  assign diff      = now_i - then_i;
  assign expired_o = (diff >= {1'b0, limit_i});

endmodule
